>>> sv/csidm_pkg.sv
// Shared types and constants for the CPU set ID mask converter.
// Holds command, status and queue item encodings used by every module.
// No dependencies.
package csidm_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MAX_GROUPS_DEF = 32;
  localparam int PROCS_DEF      = 64;

  // Field widths fixed by the port definition
  localparam int CMD_W      = 2;
  localparam int SETID_W    = 32;
  localparam int GIDX_W     = 5;
  localparam int MASK_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int ID_W       = 21;
  localparam int TOTAL_W    = 12;
  localparam int GCNT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Widest group and cpu indexes over the parameter ranges
  localparam int GROUP_W = 6;
  localparam int CPU_W   = 6;
  localparam int ACTIVE_W = 7;

  // Decoupling queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // ID encoding: group << 16 | 0x100 | cpu
  localparam logic [SETID_W-1:0] ID_BIAS = 32'h0000_0100;
  localparam int GROUP_SHIFT = 16;
  localparam logic [7:0] CPU_FIELD = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_CAP    = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_EMIT  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_ID    = 2'd1,
    STATUS_BAD_GROUP = 2'd2,
    STATUS_IGNORED   = 2'd3
  } status_e;

  // Work the back end carries out for one classified command
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD    = 3'd1,
    OP_WRITE  = 3'd2,
    OP_EMIT   = 3'd3,
    OP_REPORT = 3'd4
  } op_e;

  typedef struct packed {
    op_e                op;
    status_e            status;
    logic [GROUP_W-1:0] grp;
    logic [CPU_W-1:0]   cpu;
    logic [MASK_W-1:0]  mask;
  } item_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [ID_W-1:0]    id;
    logic               stored;
    logic               empty;
    logic [TOTAL_W-1:0] total;
    logic               fits;
    logic               last;
  } res_t;

endpackage

>>> sv/csidm_front.sv
// Front end: accepts commands, decodes IDs, checks groups and keeps the
// sticky add error. Pushes one classified item per command into the queue.
// Depends on csidm_pkg.
module csidm_front #(
  parameter int MAX_GROUPS      = csidm_pkg::MAX_GROUPS_DEF,
  parameter int PROCS_PER_GROUP = csidm_pkg::PROCS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             full_i,
  input  logic [csidm_pkg::CMD_W-1:0]      command_i,
  input  logic [csidm_pkg::SETID_W-1:0]    cpu_set_id_i,
  input  logic [csidm_pkg::GIDX_W-1:0]     group_index_i,
  input  logic [csidm_pkg::MASK_W-1:0]     mask_value_i,
  input  logic [csidm_pkg::GCNT_W-1:0]     group_count_i,
  output logic                             busy_o,
  output logic                             push_o,
  output csidm_pkg::item_t                 item_o
);

  logic                                err_q, err_d;
  logic                                accept;
  logic                                set_err;
  logic [csidm_pkg::ACTIVE_W-1:0]      active;
  logic [csidm_pkg::SETID_W-1:0]       id_off;
  logic [15:0]                         id_grp;
  logic [7:0]                          id_cpu;
  logic                                grp_ok, cpu_ok, gi_ok;
  csidm_pkg::cmd_e                     cmd;

  assign accept = start_i && !full_i;
  assign busy_o = full_i;
  assign push_o = accept;
  assign cmd    = csidm_pkg::cmd_e'(command_i);

  // Number of valid groups, capped by the table size
  assign active = (csidm_pkg::ACTIVE_W'(group_count_i) < csidm_pkg::ACTIVE_W'(MAX_GROUPS))
                ? csidm_pkg::ACTIVE_W'(group_count_i)
                : csidm_pkg::ACTIVE_W'(MAX_GROUPS);

  // Decode the ID: the group wraps for IDs below the bias
  assign id_off = cpu_set_id_i - csidm_pkg::ID_BIAS;
  assign id_grp = id_off[csidm_pkg::SETID_W-1:csidm_pkg::GROUP_SHIFT];
  assign id_cpu = cpu_set_id_i[7:0] & csidm_pkg::CPU_FIELD;

  assign grp_ok = id_grp < 16'(active);
  assign cpu_ok = id_cpu < 8'(PROCS_PER_GROUP);
  assign gi_ok  = csidm_pkg::ACTIVE_W'(group_index_i) < active;

  // Classify the command
  always_comb begin
    set_err       = 1'b0;
    item_o.op     = csidm_pkg::OP_REPORT;
    item_o.status = csidm_pkg::STATUS_OK;
    item_o.grp    = csidm_pkg::GROUP_W'(group_index_i);
    item_o.cpu    = id_cpu[csidm_pkg::CPU_W-1:0];
    item_o.mask   = mask_value_i;
    unique case (cmd)
      csidm_pkg::CMD_CLEAR: begin
        item_o.op = csidm_pkg::OP_CLEAR;
      end
      csidm_pkg::CMD_ADD: begin
        priority if (err_q) begin
          item_o.status = csidm_pkg::STATUS_IGNORED;
        end else if (!grp_ok) begin
          item_o.status = csidm_pkg::STATUS_BAD_GROUP;
          set_err       = 1'b1;
        end else if (!cpu_ok) begin
          item_o.status = csidm_pkg::STATUS_BAD_ID;
          set_err       = 1'b1;
        end else begin
          item_o.op  = csidm_pkg::OP_ADD;
          item_o.grp = id_grp[csidm_pkg::GROUP_W-1:0];
        end
      end
      csidm_pkg::CMD_WRITE: begin
        if (!gi_ok) item_o.status = csidm_pkg::STATUS_BAD_GROUP;
        else        item_o.op     = csidm_pkg::OP_WRITE;
      end
      csidm_pkg::CMD_EMIT: begin
        if (!gi_ok) item_o.status = csidm_pkg::STATUS_BAD_GROUP;
        else        item_o.op     = csidm_pkg::OP_EMIT;
      end
      default: begin
        item_o.op = csidm_pkg::OP_REPORT;
      end
    endcase
  end

  // Sticky add error: clear drops it, a bad add raises it
  always_comb begin
    err_d = err_q;
    if (accept) begin
      if (cmd == csidm_pkg::CMD_CLEAR) err_d = 1'b0;
      else if (set_err)                err_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else begin
      err_q <= err_d;
    end
  end

endmodule

>>> sv/csidm_queue.sv
// Short FIFO between the front and back ends of the converter.
// Holds classified items so either side can stall on its own.
// Depends on csidm_pkg.
module csidm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csidm_pkg::item_t  item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output csidm_pkg::item_t  item_o
);

  localparam int CNT_W = $clog2(csidm_pkg::QUEUE_DEPTH + 1);

  csidm_pkg::item_t                 ent_q [csidm_pkg::QUEUE_DEPTH];
  logic [csidm_pkg::QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(csidm_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == csidm_pkg::QPTR_W'(csidm_pkg::QUEUE_DEPTH - 1))
                      ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == csidm_pkg::QPTR_W'(csidm_pkg::QUEUE_DEPTH - 1))
                      ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= item_i;
  end

endmodule

>>> sv/csidm_back.sv
// Back end: owns the group mask memory and the running total, carries out
// clear, add, write and emit, reports rejected commands, and registers every result.
// Depends on csidm_pkg.
module csidm_back #(
  parameter int MAX_GROUPS      = csidm_pkg::MAX_GROUPS_DEF,
  parameter int PROCS_PER_GROUP = csidm_pkg::PROCS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  csidm_pkg::item_t                item_i,
  output logic                            pop_o,
  input  logic [csidm_pkg::TOTAL_W-1:0]   list_cap_i,
  output csidm_pkg::res_t                 res_o
);

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = (PROCS_PER_GROUP > 1) ? $clog2(PROCS_PER_GROUP) : 1;
  localparam int PW = PROCS_PER_GROUP;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_ADD  = 2'd1;
  localparam logic [1:0] BK_EMIT = 2'd2;
  localparam logic [1:0] BK_WALK = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [PW-1:0]                    mem [MAX_GROUPS];
  logic [MAX_GROUPS-1:0]            vld_q, vld_d;
  logic [PW-1:0]                    rd_q;
  logic                             rd_vld_q;
  logic [PW-1:0]                    walk_q, walk_d;
  logic [GW-1:0]                    g_q, g_d;
  logic [CW-1:0]                    cpu_q, cpu_d;
  logic [csidm_pkg::TOTAL_W-1:0]    total_q, total_d, total_inc;
  csidm_pkg::res_t                  res_q, res_d;

  logic                             rd_en, wr_en;
  logic [GW-1:0]                    wr_addr;
  logic [PW-1:0]                    wr_data;
  logic [PW-1:0]                    rd_word, cur, low, rest;
  logic [CW-1:0]                    bit_idx;

  assign rd_word   = rd_vld_q ? rd_q : '0;
  assign cur       = (state_q == BK_EMIT) ? rd_word : walk_q;
  assign low       = cur & (~cur + 1'b1);
  assign rest      = cur & ~low;
  assign total_inc = (total_q != '1) ? total_q + 1'b1 : total_q;
  assign pop_o     = (state_q == BK_IDLE) && valid_i;
  assign res_o     = res_q;

  // Encode the isolated lowest set bit
  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < PW; i++) begin
      if (low[i]) bit_idx = bit_idx | CW'(i);
    end
  end

  // Sequence the current command
  always_comb begin
    state_d = state_q;
    vld_d   = vld_q;
    walk_d  = walk_q;
    g_d     = g_q;
    cpu_d   = cpu_q;
    total_d = total_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = g_q;
    wr_data = rd_word | (PW'(1) << cpu_q);
    res_d        = '0;
    res_d.status = csidm_pkg::STATUS_OK;
    res_d.total  = total_q;

    unique case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          g_d   = item_i.grp[GW-1:0];
          cpu_d = item_i.cpu[CW-1:0];
          unique case (item_i.op)
            csidm_pkg::OP_CLEAR: begin
              vld_d       = '0;
              total_d     = '0;
              res_d.total = '0;
              res_d.valid = 1'b1;
              res_d.last  = 1'b1;
            end
            csidm_pkg::OP_WRITE: begin
              wr_en       = 1'b1;
              wr_addr     = item_i.grp[GW-1:0];
              wr_data     = item_i.mask[PW-1:0];
              vld_d[item_i.grp[GW-1:0]] = 1'b1;
              res_d.valid = 1'b1;
              res_d.last  = 1'b1;
            end
            csidm_pkg::OP_ADD: begin
              rd_en   = 1'b1;
              state_d = BK_ADD;
            end
            csidm_pkg::OP_EMIT: begin
              rd_en   = 1'b1;
              state_d = BK_EMIT;
            end
            default: begin
              res_d.status = item_i.status;
              res_d.valid  = 1'b1;
              res_d.last   = 1'b1;
            end
          endcase
        end
      end
      BK_ADD: begin
        wr_en       = 1'b1;
        vld_d[g_q]  = 1'b1;
        res_d.valid = 1'b1;
        res_d.last  = 1'b1;
        state_d     = BK_IDLE;
      end
      BK_EMIT, BK_WALK: begin
        res_d.valid = 1'b1;
        if (cur == '0) begin
          res_d.empty = 1'b1;
          res_d.last  = 1'b1;
          state_d     = BK_IDLE;
        end else begin
          res_d.id     = (csidm_pkg::ID_W'(g_q) << csidm_pkg::GROUP_SHIFT)
                       | csidm_pkg::ID_W'(csidm_pkg::ID_BIAS)
                       | csidm_pkg::ID_W'(bit_idx);
          res_d.stored = total_q < list_cap_i;
          res_d.total  = total_inc;
          res_d.last   = rest == '0;
          total_d      = total_inc;
          walk_d       = rest;
          state_d      = (rest == '0) ? BK_IDLE : BK_WALK;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    res_d.fits = res_d.total <= list_cap_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      vld_q   <= '0;
      total_q <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      total_q <= total_d;
      res_q   <= res_d;
    end
  end

  // Walk state
  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
    g_q    <= g_d;
    cpu_q  <= cpu_d;
  end

  // Group mask memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q     <= mem[item_i.grp[GW-1:0]];
      rd_vld_q <= vld_q[item_i.grp[GW-1:0]];
    end
  end

endmodule

>>> sv/cpu_set_id_mask_converter.sv
// Top level of the CPU set ID mask converter.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on csidm_pkg, csidm_front, csidm_queue and csidm_back.
//
// Usage:
//   Commands enter on start_i while busy_o is low: clear, add an encoded ID,
//   write a group mask word, or emit a group's IDs. Every result appears for
//   one cycle with result_valid_o high; last_o marks the final result of a
//   command. The receiver cannot stall, so results are never held back.
//   Configuration writes (group count, list capacity) use cfg_valid_i and
//   cfg_ready_o, are always taken, and belong between commands when idle.
// Flow:
//   A taken command is registered in the queue; the back end then pops it
//   and registers its result. Clear, write and rejected commands finish on
//   the pop; an add reads and then writes the mask memory; an emit reads the
//   mask memory, then gives one result per set bit, or a single empty result
//   if the mask is empty.
//   A two-entry queue lets commands be taken while the back end works;
//   busy_o is high while that queue is full.
// Reset:
//   All masks read as zero, the total and the error flag are cleared, the
//   group count is 1 and the list capacity 0.
module cpu_set_id_mask_converter #(
  parameter int MAX_GROUPS      = csidm_pkg::MAX_GROUPS_DEF,
  parameter int PROCS_PER_GROUP = csidm_pkg::PROCS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [csidm_pkg::CMD_W-1:0]       command_i,
  input  logic [csidm_pkg::SETID_W-1:0]     cpu_set_id_i,
  input  logic [csidm_pkg::GIDX_W-1:0]      group_index_i,
  input  logic [csidm_pkg::MASK_W-1:0]      mask_value_i,
  output logic                              result_valid_o,
  output logic [csidm_pkg::STATUS_W-1:0]    status_o,
  output logic [csidm_pkg::ID_W-1:0]        id_out_o,
  output logic                              id_stored_o,
  output logic                              group_empty_o,
  output logic [csidm_pkg::TOTAL_W-1:0]     total_count_o,
  output logic                              fits_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csidm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [csidm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [csidm_pkg::GCNT_W-1:0]   group_count_q;
  logic [csidm_pkg::TOTAL_W-1:0]  list_cap_q;
  logic                           push, full, pop, q_valid;
  csidm_pkg::item_t               push_item, pop_item;
  csidm_pkg::res_t                res;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= csidm_pkg::GCNT_W'(1);
      list_cap_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == csidm_pkg::CFG_GROUP_COUNT) begin
        group_count_q <= cfg_data_i[csidm_pkg::GCNT_W-1:0];
      end else if (cfg_index_i == csidm_pkg::CFG_LIST_CAP) begin
        list_cap_q <= cfg_data_i[csidm_pkg::TOTAL_W-1:0];
      end
    end
  end

  csidm_front #(
    .MAX_GROUPS      (MAX_GROUPS),
    .PROCS_PER_GROUP (PROCS_PER_GROUP)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .full_i        (full),
    .command_i     (command_i),
    .cpu_set_id_i  (cpu_set_id_i),
    .group_index_i (group_index_i),
    .mask_value_i  (mask_value_i),
    .group_count_i (group_count_q),
    .busy_o        (busy_o),
    .push_o        (push),
    .item_o        (push_item)
  );

  csidm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  csidm_back #(
    .MAX_GROUPS      (MAX_GROUPS),
    .PROCS_PER_GROUP (PROCS_PER_GROUP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (pop_item),
    .pop_o      (pop),
    .list_cap_i (list_cap_q),
    .res_o      (res)
  );

  // Drive the result ports
  assign result_valid_o = res.valid;
  assign status_o       = res.status;
  assign id_out_o       = res.id;
  assign id_stored_o    = res.stored;
  assign group_empty_o  = res.empty;
  assign total_count_o  = res.total;
  assign fits_o         = res.fits;
  assign last_o         = res.last;

endmodule

>>> sv/csidm_checker.sv
// Port-level checks for the CPU set ID mask converter, bound to the top.
// Depends on csidm_pkg and cpu_set_id_mask_converter.
module csidm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              result_valid_o,
  input logic [csidm_pkg::STATUS_W-1:0]    status_o,
  input logic [csidm_pkg::ID_W-1:0]        id_out_o,
  input logic                              id_stored_o,
  input logic                              group_empty_o,
  input logic [csidm_pkg::TOTAL_W-1:0]     total_count_o,
  input logic                              fits_o,
  input logic                              last_o
);

  // An empty group gives a single result with no ID
  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && group_empty_o |-> last_o && (id_out_o == '0) && !id_stored_o)
    else $error("empty group result carries an ID or is not last");

  // A rejected command ends in one result
  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != csidm_pkg::STATUS_OK) |-> last_o && !group_empty_o)
    else $error("rejected command gave more than one result");

  // A stored ID always leaves the total within capacity
  a_stored_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && id_stored_o |-> fits_o)
    else $error("stored ID but total exceeds capacity");

  // An emit walk delivers its IDs in back-to-back cycles
  a_walk_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("gap inside an emit walk");

  // Each further ID of a walk advances the total by one until it saturates
  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=>
      (total_count_o == $past(total_count_o) + 1'b1) || ($past(total_count_o) == '1))
    else $error("running total did not advance");

endmodule

bind cpu_set_id_mask_converter csidm_checker u_csidm_checker (.*);
